// ===== hdl/double_ended_queue_assert.svh =====
// Assertion macros for the double-ended queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define DQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Depends on nothing; used by double_ended_queue and the testbench.
package dq_pkg;

    // Default sizing of the ring store
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Fixed widths of the beat fields
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int STATUS_W = 2;

    // Operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_RIGHT = 3'd0,
        KIND_POP_LEFT   = 3'd1,
        KIND_POP_RIGHT  = 3'd2,
        KIND_PEEK_LEFT  = 3'd3,
        KIND_PEEK_RIGHT = 3'd4
    } dq_kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } dq_status_t;

    // Input beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] push_value;
    } dq_in_t;

    // Result beat
    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
    } dq_out_t;

endpackage

// ===== hdl/dq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instanced by double_ended_queue for the ring store.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue top level: ring store in a RAM, end pointer and count.
// Depends on dq_pkg, dq_ram and double_ended_queue_assert.svh.
//
//   channel | dir | handshake          | beat
//   s_      | in  | s_valid / s_ready  | dq_pkg::dq_in_t  (kind, push_value)
//   m_      | out | m_valid / m_ready  | dq_pkg::dq_out_t (value, count, empty, status)
//
// One operation per cycle sustained while m_ready holds; the accepting edge loads the
// RAM read and read stage, and the output register then raises m_valid.
// Pointer and count update at acceptance, so back-to-back operations see the
// latest ends without forwarding; the single RAM port pair sets the rate.
// aresetn is synchronous and active low and empties the queue; no clearing pass.
// A stall on m_ready holds the output register, then the read stage, then s_ready.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dq_pkg::dq_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dq_pkg::dq_out_t m_data
);

    `include "double_ended_queue_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Queue state
    logic [AW-1:0] left_reg, left_next;
    logic [CW-1:0] count_reg, count_next;

    // Read stage
    logic                p1_valid_reg, p1_valid_next;
    dq_pkg::dq_status_t  p1_status_reg, p1_status_next;
    logic [CW-1:0]       p1_count_reg, p1_count_next;
    logic                p1_use_ram_reg, p1_use_ram_next;

    // Output register
    logic            m_valid_reg, m_valid_next;
    dq_pkg::dq_out_t m_data_reg, m_data_next;

    // RAM ports
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [63:0]           rdata_wide;

    logic               s_fire;
    logic               out_free;
    logic               p1_move;
    logic               is_full;
    logic               is_zero;
    logic [SW-1:0]      slot_sum;
    logic [SW-1:0]      tail_sum;
    logic [AW-1:0]      push_addr;
    logic [AW-1:0]      right_addr;
    logic [AW-1:0]      left_inc;
    dq_pkg::dq_status_t op_status;

    assign out_free = !m_valid_reg || m_ready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    assign is_full = (count_reg == CW'(DEPTH));
    assign is_zero = (count_reg == '0);

    // Ring addresses of both ends; the sum stays below twice the depth
    assign slot_sum   = SW'(left_reg) + SW'(count_reg);
    assign tail_sum   = slot_sum - SW'(1);
    assign push_addr  = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH))
                                                 : AW'(slot_sum);
    assign right_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                 : AW'(tail_sum);
    assign left_inc   = (left_reg == AW'(DEPTH - 1)) ? '0 : left_reg + AW'(1);

    assign ram_waddr = push_addr;
    assign ram_wdata = DATA_WIDTH'(s_data.push_value);

    // Decode the operation, drive the RAM and advance the ends
    always_comb begin
        left_next  = left_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = left_reg;
        op_status  = dq_pkg::STATUS_OK;
        if (s_fire) begin
            case (s_data.kind)
                dq_pkg::KIND_PUSH_RIGHT: begin
                    if (is_full) begin
                        op_status = dq_pkg::STATUS_OVERFLOW;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                dq_pkg::KIND_POP_LEFT: begin
                    if (is_zero) begin
                        op_status = dq_pkg::STATUS_UNDERFLOW;
                    end else begin
                        ram_re     = 1'b1;
                        left_next  = left_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                dq_pkg::KIND_POP_RIGHT: begin
                    if (is_zero) begin
                        op_status = dq_pkg::STATUS_UNDERFLOW;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = right_addr;
                        count_next = count_reg - CW'(1);
                    end
                end
                dq_pkg::KIND_PEEK_LEFT: begin
                    if (is_zero) begin
                        op_status = dq_pkg::STATUS_UNDERFLOW;
                    end else begin
                        ram_re = 1'b1;
                    end
                end
                dq_pkg::KIND_PEEK_RIGHT: begin
                    if (is_zero) begin
                        op_status = dq_pkg::STATUS_UNDERFLOW;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = right_addr;
                    end
                end
                default: begin
                    op_status = dq_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // Read stage: hold the result fields while the RAM read completes
    always_comb begin
        p1_valid_next   = p1_valid_reg;
        p1_status_next  = p1_status_reg;
        p1_count_next   = p1_count_reg;
        p1_use_ram_next = p1_use_ram_reg;
        if (s_fire) begin
            p1_valid_next   = 1'b1;
            p1_status_next  = op_status;
            p1_count_next   = count_next;
            p1_use_ram_next = ram_re;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end
    end

    assign rdata_wide = 64'(ram_rdata);

    // Output register: load from the read stage, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (p1_move) begin
            m_valid_next            = 1'b1;
            m_data_next.read_value  = p1_use_ram_reg ? rdata_wide[dq_pkg::VALUE_W-1:0] : '0;
            m_data_next.entry_count = dq_pkg::COUNT_W'(p1_count_reg);
            m_data_next.is_empty    = (p1_count_reg == '0);
            m_data_next.status      = p1_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            left_reg     <= left_next;
            count_reg    <= count_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p1_status_reg  <= p1_status_next;
        p1_count_reg   <= p1_count_next;
        p1_use_ram_reg <= p1_use_ram_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `DQ_ASSERT_ALWAYS(a_count_bound, aclk, !aresetn || (count_reg <= CW'(DEPTH)), "entry count above depth")
    `DQ_ASSERT_ALWAYS(a_left_bound, aclk, !aresetn || (left_reg <= AW'(DEPTH - 1)), "left pointer outside ring")
    `DQ_ASSERT(a_push_counts, aclk, aresetn, (s_fire && (s_data.kind == dq_pkg::KIND_PUSH_RIGHT) && !is_full) |=> (count_reg == CW'($past(count_reg) + CW'(1))), "accepted push did not raise the count")
    `DQ_ASSERT(a_underflow_zero, aclk, aresetn, (m_valid_reg && (m_data_reg.status == dq_pkg::STATUS_UNDERFLOW)) |-> (m_data_reg.read_value == '0), "underflow result carries data")

endmodule

// ===== verif/deque_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the double-ended queue: mirrors the ring store, predicts
// every result beat from the accepted operations and compares field by field.
// Depends on dq_pkg.
module deque_result_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  dq_pkg::dq_in_t  s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  dq_pkg::dq_out_t m_data,
    output int              fail_count,
    output int              results_owed
);
    import dq_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEFAULT;

    // Mirror of the deque: ring words, left end and occupancy
    logic [VALUE_W-1:0] ring_word [RING_DEPTH];
    int                 head_slot = 0;
    int                 occupancy = 0;

    // Predicted result beats, oldest first
    dq_out_t            deque_replies_due [$];
    int                 mismatches = 0;

    // Apply one operation to the mirror and return the beat it should produce
    function automatic dq_out_t deque_apply(dq_in_t op);
        dq_out_t reply;
        int      tail_slot;
        reply = '0;
        reply.status = STATUS_OK;
        tail_slot = (head_slot + occupancy + RING_DEPTH - 1) % RING_DEPTH;
        case (op.kind)
            KIND_PUSH_RIGHT: begin
                // drop the word when the ring is full
                if (occupancy == RING_DEPTH) begin
                    reply.status = STATUS_OVERFLOW;
                end else begin
                    ring_word[(head_slot + occupancy) % RING_DEPTH] = op.push_value;
                    occupancy++;
                end
            end
            KIND_POP_LEFT, KIND_POP_RIGHT, KIND_PEEK_LEFT, KIND_PEEK_RIGHT: begin
                if (occupancy == 0) begin
                    reply.status = STATUS_UNDERFLOW;
                end else begin
                    if (op.kind == KIND_POP_LEFT || op.kind == KIND_PEEK_LEFT) begin
                        reply.read_value = ring_word[head_slot];
                    end else begin
                        reply.read_value = ring_word[tail_slot];
                    end
                    // advance the left end or shorten from the right
                    if (op.kind == KIND_POP_LEFT) begin
                        head_slot = (head_slot + 1) % RING_DEPTH;
                        occupancy--;
                    end else if (op.kind == KIND_POP_RIGHT) begin
                        occupancy--;
                    end
                end
            end
            default: begin
                // unused codes leave the state alone
            end
        endcase
        reply.entry_count = COUNT_W'(occupancy);
        reply.is_empty = (occupancy == 0);
        return reply;
    endfunction

    always @(posedge aclk) begin
        dq_out_t due;
        if (!aresetn) begin
            head_slot = 0;
            occupancy = 0;
            deque_replies_due.delete();
        end else begin
            // compare a returned beat with the oldest prediction
            if (m_valid && m_ready) begin
                if (deque_replies_due.size() == 0) begin
                    $error("result beat with no operation outstanding");
                    mismatches++;
                end else begin
                    due = deque_replies_due.pop_front();
                    if (m_data.read_value !== due.read_value) begin
                        $error("read_value: expected %h, got %h",
                               due.read_value, m_data.read_value);
                        mismatches++;
                    end
                    if (m_data.entry_count !== due.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               due.entry_count, m_data.entry_count);
                        mismatches++;
                    end
                    if (m_data.is_empty !== due.is_empty) begin
                        $error("is_empty: expected %b, got %b",
                               due.is_empty, m_data.is_empty);
                        mismatches++;
                    end
                    if (m_data.status !== due.status) begin
                        $error("status: expected %0d, got %0d",
                               due.status, m_data.status);
                        mismatches++;
                    end
                end
            end
            // predict the beat for an accepted operation and queue it last
            if (s_valid && s_ready) begin
                deque_replies_due.insert(deque_replies_due.size(), deque_apply(s_data));
            end
        end
        fail_count <= mismatches;
        results_owed <= deque_replies_due.size();
    end

endmodule

// ===== verif/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: clock, reset, operation and
// result-side traffic with random idling, and the final verdict.
// Depends on dq_pkg, double_ended_queue and deque_result_checker.
module double_ended_queue_tb;
    import dq_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 90;
    localparam int RANDOM_OPS      = 1300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RESET_CYCLES    = 5;

    // Operation codes the block does not define
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CODE_MAX     = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    dq_in_t  s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    dq_out_t m_data;

    int fail_count;
    int results_owed;
    int idle_cycles  = 0;
    bit steady_flow  = 1'b0;
    bit hold_request = 1'b0;

    double_ended_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    deque_result_checker result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Idle cycles before the next beat on either side
    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 5);
    endfunction

    // Choose an operation, weighted to drive the deque full, empty or neither
    function automatic logic [KIND_W-1:0] pick_kind(op_mix_t mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                push_pct = 80;
                pop_pct  = 10;
            end
            MIX_DRAIN: begin
                push_pct = 10;
                pop_pct  = 75;
            end
            default: begin
                push_pct = 40;
                pop_pct  = 40;
            end
        endcase
        if (roll < 3) begin
            return KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_CODE_MAX));
        end else if (roll < 3 + push_pct) begin
            return KIND_PUSH_RIGHT;
        end else if (roll < 3 + push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? KIND_POP_LEFT : KIND_POP_RIGHT;
        end else begin
            return $urandom_range(0, 1) ? KIND_PEEK_LEFT : KIND_PEEK_RIGHT;
        end
    endfunction

    // Offer one operation beat and hold it until the block takes it
    task automatic offer_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.kind <= kind;
        s_data.push_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait for every outstanding result beat
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    // Operation side: directed sequence, then random blocks
    initial begin : stimulus
        op_mix_t           mix;
        int                block_len;
        int                block_no;
        int                ops_sent;
        logic [KIND_W-1:0] kind;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // underflow and unused codes on an empty deque
        offer_op(KIND_PEEK_LEFT, $urandom());
        offer_op(KIND_PEEK_RIGHT, $urandom());
        offer_op(KIND_POP_LEFT, $urandom());
        offer_op(KIND_POP_RIGHT, $urandom());
        offer_op(KIND_UNUSED_FIRST, $urandom());
        offer_op(KIND_UNUSED_MID, $urandom());
        offer_op(KIND_CODE_MAX, $urandom());
        // extreme words, then reads from both ends down to underflow
        offer_op(KIND_PUSH_RIGHT, 32'h0000_0000);
        offer_op(KIND_PUSH_RIGHT, 32'hFFFF_FFFF);
        offer_op(KIND_PUSH_RIGHT, 32'hA5A5_5A5A);
        offer_op(KIND_PEEK_LEFT, $urandom());
        offer_op(KIND_PEEK_RIGHT, $urandom());
        offer_op(KIND_UNUSED_MID, $urandom());
        offer_op(KIND_POP_RIGHT, $urandom());
        offer_op(KIND_POP_LEFT, $urandom());
        offer_op(KIND_PEEK_LEFT, $urandom());
        offer_op(KIND_POP_LEFT, $urandom());
        offer_op(KIND_POP_LEFT, $urandom());

        // random blocks cycling through fill, drain and even mixes
        ops_sent = 0;
        block_no = 0;
        while (ops_sent < RANDOM_OPS) begin
            mix = op_mix_t'(block_no % 3);
            steady_flow = ($urandom_range(0, 3) == 0);
            if (block_no == 3) begin
                hold_request = 1'b1;
            end
            if (block_no % 7 == 5) begin
                wait_for_quiet();
            end
            block_len = $urandom_range(30, 60);
            repeat (block_len) begin
                kind = pick_kind(mix);
                offer_op(kind, $urandom());
                if (kind <= KIND_PEEK_RIGHT) begin
                    ops_sent++;
                end
            end
            block_no++;
        end

        wait_for_quiet();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("double_ended_queue_tb OK");
        end else begin
            $display("double_ended_queue_tb NOT OK");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // End the run if neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("double_ended_queue_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== double_ended_queue.f =====
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/double_ended_queue.sv
verif/deque_result_checker.sv
verif/double_ended_queue_tb.sv
